[rtl/slaf_pkg.sv]
// Shared types and constants of the spotlight attenuation and falloff pipeline.
package slaf_pkg;

  // Square root steps: one result bit per stage for a 62-bit radicand.
  localparam int unsigned SQRT_STEPS = 31;
  // Normalizing divider steps: one quotient bit per stage, 18-bit quotient.
  localparam int unsigned NDIV_STEPS = 18;
  // Register stages from the vector input to the unit vector output.
  localparam int unsigned NORM_LAT   = 3 + SQRT_STEPS + 1 + NDIV_STEPS + 1;

  // 1.0 in unsigned Q1.16.
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Unit vector in signed Q1.16 plus a flag for a zero-length input vector.
  typedef struct packed {
    logic [17:0] unit_x;
    logic [17:0] unit_y;
    logic [17:0] unit_z;
    logic        zero;
  } norm_t;

endpackage

[rtl/slaf_norm.sv]
// Pipelined vector normalizer: squares, sum, bit-serial square root and three dividers.
module slaf_norm
  import slaf_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [23:0] x_i,
  input  logic [23:0] y_i,
  input  logic [23:0] z_i,
  output norm_t       norm_o
);

  logic [23:0] in_c [3];

  assign in_c[0] = x_i;
  assign in_c[1] = y_i;
  assign in_c[2] = z_i;

  // Stage 1: component magnitudes and signs.
  logic [23:0] s1_mag_q [3];
  logic [2:0]  s1_neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag_q[i] <= in_c[i][23] ? (~in_c[i] + 24'd1) : in_c[i];
        s1_neg_q[i] <= in_c[i][23];
      end
    end
  end

  // Stage 2: squares of the magnitudes.
  logic [47:0] s2_sq_d  [3];
  logic [46:0] s2_sq_q  [3];
  logic [23:0] s2_mag_q [3];
  logic [2:0]  s2_neg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_sq_d[i] = s1_mag_q[i] * s1_mag_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i]  <= s2_sq_d[i][46:0];
        s2_mag_q[i] <= s1_mag_q[i];
      end
      s2_neg_q <= s1_neg_q;
    end
  end

  // Stage 3: sum of squares and the zero-vector flag.
  logic [47:0] s3_sum_d;
  logic [47:0] s3_sum_q;
  logic [23:0] s3_mag_q [3];
  logic [2:0]  s3_neg_q;
  logic        s3_zero_q;

  assign s3_sum_d = {1'b0, s2_sq_q[0]} + {1'b0, s2_sq_q[1]} + {1'b0, s2_sq_q[2]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_sum_q  <= s3_sum_d;
      s3_mag_q  <= s2_mag_q;
      s3_neg_q  <= s2_neg_q;
      s3_zero_q <= (s3_sum_d == 48'd0);
    end
  end

  // Square root of sum << 14, two radicand bits and one root bit per stage.
  logic [32:0]           sq_rem_q  [SQRT_STEPS];
  logic [30:0]           sq_root_q [SQRT_STEPS];
  logic [61:0]           sq_x_q    [SQRT_STEPS];
  logic [23:0]           sq_mag_q  [SQRT_STEPS][3];
  logic [2:0]            sq_neg_q  [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sq_zero_q;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [32:0] rem_in;
    logic [30:0] root_in;
    logic [61:0] x_in;
    logic [23:0] mag_in [3];
    logic [2:0]  neg_in;
    logic        zero_in;
    logic [34:0] cur;
    logic [34:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = {s3_sum_q, 14'd0};
      assign mag_in  = s3_mag_q;
      assign neg_in  = s3_neg_q;
      assign zero_in = s3_zero_q;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign x_in    = sq_x_q[k-1];
      assign mag_in  = sq_mag_q[k-1];
      assign neg_in  = sq_neg_q[k-1];
      assign zero_in = sq_zero_q[k-1];
    end

    assign cur   = {rem_in, x_in[61:60]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cur >= trial) begin
          sq_rem_q[k]  <= 33'(cur - trial);
          sq_root_q[k] <= {root_in[29:0], 1'b1};
        end else begin
          sq_rem_q[k]  <= cur[32:0];
          sq_root_q[k] <= {root_in[29:0], 1'b0};
        end
        sq_x_q[k]    <= {x_in[59:0], 2'b00};
        sq_mag_q[k]  <= mag_in;
        sq_neg_q[k]  <= neg_in;
        sq_zero_q[k] <= zero_in;
      end
    end
  end

  // Dividend stage: magnitude << 23 plus half the norm for rounding.
  logic [46:0] nd_num_q [3];
  logic [30:0] nd_den_q;
  logic [2:0]  nd_neg_q;
  logic        nd_zero_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        nd_num_q[i] <= {sq_mag_q[SQRT_STEPS-1][i], 23'd0}
                     + {17'd0, sq_root_q[SQRT_STEPS-1][30:1]};
      end
      nd_den_q  <= sq_root_q[SQRT_STEPS-1];
      nd_neg_q  <= sq_neg_q[SQRT_STEPS-1];
      nd_zero_q <= sq_zero_q[SQRT_STEPS-1];
    end
  end

  // Restoring dividers, one quotient bit per stage for all three lanes.
  logic [46:0]           dv_rem_q [NDIV_STEPS][3];
  logic [17:0]           dv_quo_q [NDIV_STEPS][3];
  logic [30:0]           dv_den_q [NDIV_STEPS];
  logic [2:0]            dv_neg_q [NDIV_STEPS];
  logic [NDIV_STEPS-1:0] dv_zero_q;

  for (genvar t = 0; t < NDIV_STEPS; t++) begin : g_div
    localparam int unsigned J = NDIV_STEPS - 1 - t;
    logic [46:0] rem_in [3];
    logic [17:0] quo_in [3];
    logic [30:0] den_in;
    logic [2:0]  neg_in;
    logic        zero_in;
    logic [47:0] dsh;

    if (t == 0) begin : g_first
      assign rem_in  = nd_num_q;
      assign quo_in  = '{default: '0};
      assign den_in  = nd_den_q;
      assign neg_in  = nd_neg_q;
      assign zero_in = nd_zero_q;
    end else begin : g_next
      assign rem_in  = dv_rem_q[t-1];
      assign quo_in  = dv_quo_q[t-1];
      assign den_in  = dv_den_q[t-1];
      assign neg_in  = dv_neg_q[t-1];
      assign zero_in = dv_zero_q[t-1];
    end

    assign dsh = {17'd0, den_in} << J;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          if ({1'b0, rem_in[i]} >= dsh) begin
            dv_rem_q[t][i] <= rem_in[i] - dsh[46:0];
            dv_quo_q[t][i] <= {quo_in[i][16:0], 1'b1};
          end else begin
            dv_rem_q[t][i] <= rem_in[i];
            dv_quo_q[t][i] <= {quo_in[i][16:0], 1'b0};
          end
        end
        dv_den_q[t]  <= den_in;
        dv_neg_q[t]  <= neg_in;
        dv_zero_q[t] <= zero_in;
      end
    end
  end

  // Output stage: saturate to 1.0 and restore the component signs.
  logic [17:0] un_d [3];
  norm_t       norm_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_quo_q[NDIV_STEPS-1][i] > {1'b0, ONE_Q16}) begin
        un_d[i] = {1'b0, ONE_Q16};
      end else begin
        un_d[i] = dv_quo_q[NDIV_STEPS-1][i];
      end
      if (dv_neg_q[NDIV_STEPS-1][i]) begin
        un_d[i] = 18'd0 - un_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q.unit_x <= un_d[0];
      norm_q.unit_y <= un_d[1];
      norm_q.unit_z <= un_d[2];
      norm_q.zero   <= dv_zero_q[NDIV_STEPS-1];
    end
  end

  assign norm_o = norm_q;

endmodule

[rtl/spot_light_attenuation_falloff.sv]
// Spotlight stage: distance attenuation and cone falloff for one fragment word per clock
// while the pipeline advances. Throughput is one word per cycle unless a held output stalls
// the pipeline; the cone path (square root, normalizing and falloff dividers, one bit per
// stage) sets the depth and the attenuation result is delayed to match.
// When the output is stalled the pipeline keeps moving until a word reaches its last stage.
// Reset clears all valid bits and loads the configuration registers with their default light settings.
module spot_light_attenuation_falloff
  import slaf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] vec_x_i,
  input  logic signed [23:0] vec_y_i,
  input  logic signed [23:0] vec_z_i,
  input  logic [23:0]        frag_distance_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [16:0]        attenuation_o,
  output logic [16:0]        cone_falloff_o
);

  localparam int unsigned ADIV_STEPS = 17;
  localparam int unsigned FDIV_STEPS = 16;
  localparam int unsigned ATT_LAT    = 5 + ADIV_STEPS + 1;
  localparam int unsigned FALL_LAT   = NORM_LAT + 4 + FDIV_STEPS + 1;
  localparam int unsigned ATT_PAD    = FALL_LAT - ATT_LAT;

  typedef enum logic [2:0] {
    REG_LINEAR    = 3'd0,
    REG_QUADRATIC = 3'd1,
    REG_RANGE     = 3'd2,
    REG_COS_INNER = 3'd3,
    REG_COS_OUTER = 3'd4,
    REG_DIR_X     = 3'd5,
    REG_DIR_Y     = 3'd6,
    REG_DIR_Z     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic zero;
    logic eps_zero;
    logic num_ge;
    logic kill;
    logic sat;
  } fflag_t;

  // Configuration registers.
  logic [23:0]        linear_q;
  logic [23:0]        quad_q;
  logic [23:0]        range_q;
  logic signed [17:0] cos_inner_q;
  logic signed [17:0] cos_outer_q;
  logic [23:0]        dir_x_q;
  logic [23:0]        dir_y_q;
  logic [23:0]        dir_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_q    <= 24'd5898;
      quad_q      <= 24'd2097;
      range_q     <= 24'd81920;
      cos_inner_q <= 18'sd63983;
      cos_outer_q <= 18'sd62503;
      dir_x_q     <= 24'd0;
      dir_y_q     <= 24'hFF0000;
      dir_z_q     <= 24'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LINEAR:    linear_q    <= cfg_data_i;
        REG_QUADRATIC: quad_q      <= cfg_data_i;
        REG_RANGE:     range_q     <= cfg_data_i;
        REG_COS_INNER: cos_inner_q <= $signed(cfg_data_i[17:0]);
        REG_COS_OUTER: cos_outer_q <= $signed(cfg_data_i[17:0]);
        REG_DIR_X:     dir_x_q     <= cfg_data_i;
        REG_DIR_Y:     dir_y_q     <= cfg_data_i;
        REG_DIR_Z:     dir_z_q     <= cfg_data_i;
        default:       linear_q    <= linear_q;
      endcase
    end
  end

  // Pipeline advance: everything moves unless a finished word is blocked behind a held output.
  logic                adv;
  logic                out_hold;
  logic [FALL_LAT-1:0] vld_q;
  logic                out_valid_q;

  assign out_hold   = out_valid_q & out_stall_i;
  assign adv        = ~(vld_q[FALL_LAT-1] & out_hold);
  assign in_stall_o = ~adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[FALL_LAT-2:0], in_valid_i};
    end
  end

  // ---------------- Attenuation path ----------------

  // Stage a1: d squared, linear term, range test.
  logic [47:0] a1_dd_d;
  logic [47:0] a1_lin_d;
  logic [47:0] a1_dd_q;
  logic [47:0] a1_lin_q;
  logic        a1_far_q;

  assign a1_dd_d  = frag_distance_i * frag_distance_i;
  assign a1_lin_d = linear_q * frag_distance_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_dd_q  <= a1_dd_d;
      a1_lin_q <= a1_lin_d;
      a1_far_q <= (frag_distance_i > range_q);
    end
  end

  // Stage a2: quadratic term as two partial products of d^2 >> 12.
  logic [41:0] a2_pl_d;
  logic [41:0] a2_ph_d;
  logic [41:0] a2_pl_q;
  logic [41:0] a2_ph_q;
  logic [47:0] a2_lin_q;
  logic        a2_far_q;

  assign a2_pl_d = quad_q * a1_dd_q[29:12];
  assign a2_ph_d = quad_q * a1_dd_q[47:30];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a2_pl_q  <= a2_pl_d;
      a2_ph_q  <= a2_ph_d;
      a2_lin_q <= a1_lin_q;
      a2_far_q <= a1_far_q;
    end
  end

  // Stage a3: combine the partial products.
  logic [59:0] a3_qd_q;
  logic [47:0] a3_lin_q;
  logic        a3_far_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a3_qd_q  <= {a2_ph_q[41:0], 18'd0} + {18'd0, a2_pl_q};
      a3_lin_q <= a2_lin_q;
      a3_far_q <= a2_far_q;
    end
  end

  // Stage a4: denominator in Q.28.
  logic [60:0] a4_den_q;
  logic        a4_far_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a4_den_q <= (61'd1 << 28) + {13'd0, a3_lin_q} + {1'b0, a3_qd_q};
      a4_far_q <= a3_far_q;
    end
  end

  // Stage a5: rounded dividend 2^44 + den/2.
  logic [61:0] a5_num_q;
  logic [60:0] a5_den_q;
  logic        a5_far_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a5_num_q <= (62'd1 << 44) + {2'b00, a4_den_q[60:1]};
      a5_den_q <= a4_den_q;
      a5_far_q <= a4_far_q;
    end
  end

  // Attenuation divider, one quotient bit per stage.
  logic [61:0]           ad_rem_q [ADIV_STEPS];
  logic [16:0]           ad_quo_q [ADIV_STEPS];
  logic [60:0]           ad_den_q [ADIV_STEPS];
  logic [ADIV_STEPS-1:0] ad_far_q;

  for (genvar t = 0; t < ADIV_STEPS; t++) begin : g_adiv
    localparam int unsigned J = ADIV_STEPS - 1 - t;
    logic [61:0] rem_in;
    logic [16:0] quo_in;
    logic [60:0] den_in;
    logic        far_in;
    logic [77:0] dsh;

    if (t == 0) begin : g_first
      assign rem_in = a5_num_q;
      assign quo_in = '0;
      assign den_in = a5_den_q;
      assign far_in = a5_far_q;
    end else begin : g_next
      assign rem_in = ad_rem_q[t-1];
      assign quo_in = ad_quo_q[t-1];
      assign den_in = ad_den_q[t-1];
      assign far_in = ad_far_q[t-1];
    end

    assign dsh = {17'd0, den_in} << J;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if ({16'd0, rem_in} >= dsh) begin
          ad_rem_q[t] <= rem_in - dsh[61:0];
          ad_quo_q[t] <= {quo_in[15:0], 1'b1};
        end else begin
          ad_rem_q[t] <= rem_in;
          ad_quo_q[t] <= {quo_in[15:0], 1'b0};
        end
        ad_den_q[t] <= den_in;
        ad_far_q[t] <= far_in;
      end
    end
  end

  // Attenuation result, then a delay line to line up with the cone path.
  logic [16:0] att_q;
  logic [16:0] att_dly_q [ATT_PAD];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      att_q        <= ad_far_q[ADIV_STEPS-1] ? 17'd0 : ad_quo_q[ADIV_STEPS-1];
      att_dly_q[0] <= att_q;
      for (int i = 1; i < ATT_PAD; i++) begin
        att_dly_q[i] <= att_dly_q[i-1];
      end
    end
  end

  // ---------------- Cone falloff path ----------------

  norm_t nrm_frag;
  norm_t nrm_dir;

  slaf_norm u_norm_frag (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    (vec_x_i),
    .y_i    (vec_y_i),
    .z_i    (vec_z_i),
    .norm_o (nrm_frag)
  );

  slaf_norm u_norm_dir (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    (dir_x_q),
    .y_i    (dir_y_q),
    .z_i    (dir_z_q),
    .norm_o (nrm_dir)
  );

  // Stage f1: component products of the two unit vectors.
  logic signed [35:0] f1_p_d [3];
  logic signed [35:0] f1_p_q [3];
  logic               f1_zero_q;

  assign f1_p_d[0] = $signed(nrm_frag.unit_x) * $signed(nrm_dir.unit_x);
  assign f1_p_d[1] = $signed(nrm_frag.unit_y) * $signed(nrm_dir.unit_y);
  assign f1_p_d[2] = $signed(nrm_frag.unit_z) * $signed(nrm_dir.unit_z);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_p_q    <= f1_p_d;
      f1_zero_q <= nrm_frag.zero | nrm_dir.zero;
    end
  end

  // Stage f2: dot product, round to Q1.16 and clamp to -1..1.
  logic signed [37:0] f2_sum;
  logic signed [37:0] f2_rnd;
  logic signed [21:0] f2_t;
  logic signed [17:0] f2_theta_d;
  logic signed [17:0] f2_theta_q;
  logic               f2_zero_q;

  assign f2_sum = {{2{f1_p_q[0][35]}}, f1_p_q[0]} + {{2{f1_p_q[1][35]}}, f1_p_q[1]}
                + {{2{f1_p_q[2][35]}}, f1_p_q[2]};
  assign f2_rnd = f2_sum + 38'sd32768;
  assign f2_t   = $signed(f2_rnd[37:16]);

  always_comb begin
    if (f2_t > 22'sd65536) begin
      f2_theta_d = 18'sd65536;
    end else if (f2_t < -22'sd65536) begin
      f2_theta_d = -18'sd65536;
    end else begin
      f2_theta_d = f2_t[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f2_theta_q <= f2_theta_d;
      f2_zero_q  <= f1_zero_q;
    end
  end

  // Stage f3: numerator and cone width.
  logic signed [18:0] f3_num_q;
  logic signed [18:0] f3_eps_q;
  logic               f3_zero_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f3_num_q  <= {f2_theta_q[17], f2_theta_q} - {cos_outer_q[17], cos_outer_q};
      f3_eps_q  <= {cos_inner_q[17], cos_inner_q} - {cos_outer_q[17], cos_outer_q};
      f3_zero_q <= f2_zero_q;
    end
  end

  // Stage f4: magnitudes and the special-case flags.
  logic [18:0] f4_nneg;
  logic [18:0] f4_eneg;
  logic [17:0] f4_anum_d;
  logic [17:0] f4_aeps_d;
  logic [17:0] f4_anum_q;
  logic [17:0] f4_aeps_q;
  fflag_t      f4_flag_q;

  assign f4_nneg   = 19'd0 - f3_num_q;
  assign f4_eneg   = 19'd0 - f3_eps_q;
  assign f4_anum_d = f3_num_q[18] ? f4_nneg[17:0] : f3_num_q[17:0];
  assign f4_aeps_d = f3_eps_q[18] ? f4_eneg[17:0] : f3_eps_q[17:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f4_anum_q          <= f4_anum_d;
      f4_aeps_q          <= f4_aeps_d;
      f4_flag_q.zero     <= f3_zero_q;
      f4_flag_q.eps_zero <= (f3_eps_q == 19'sd0);
      f4_flag_q.num_ge   <= ~f3_num_q[18];
      f4_flag_q.kill     <= (f3_num_q == 19'sd0) | (f3_num_q[18] ^ f3_eps_q[18]);
      f4_flag_q.sat      <= (f4_anum_d >= f4_aeps_d);
    end
  end

  // Falloff divider: (|num| << 16) / |eps|, one quotient bit per stage.
  logic [33:0] fd_rem_q  [FDIV_STEPS];
  logic [15:0] fd_quo_q  [FDIV_STEPS];
  logic [17:0] fd_aeps_q [FDIV_STEPS];
  fflag_t      fd_flag_q [FDIV_STEPS];

  for (genvar t = 0; t < FDIV_STEPS; t++) begin : g_fdiv
    localparam int unsigned J = FDIV_STEPS - 1 - t;
    logic [33:0] rem_in;
    logic [15:0] quo_in;
    logic [17:0] aeps_in;
    fflag_t      flag_in;
    logic [33:0] dsh;

    if (t == 0) begin : g_first
      assign rem_in  = {f4_anum_q, 16'd0};
      assign quo_in  = '0;
      assign aeps_in = f4_aeps_q;
      assign flag_in = f4_flag_q;
    end else begin : g_next
      assign rem_in  = fd_rem_q[t-1];
      assign quo_in  = fd_quo_q[t-1];
      assign aeps_in = fd_aeps_q[t-1];
      assign flag_in = fd_flag_q[t-1];
    end

    assign dsh = {16'd0, aeps_in} << J;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rem_in >= dsh) begin
          fd_rem_q[t] <= rem_in - dsh;
          fd_quo_q[t] <= {quo_in[14:0], 1'b1};
        end else begin
          fd_rem_q[t] <= rem_in;
          fd_quo_q[t] <= {quo_in[14:0], 1'b0};
        end
        fd_aeps_q[t] <= aeps_in;
        fd_flag_q[t] <= flag_in;
      end
    end
  end

  // Falloff result with the special cases applied in priority order.
  fflag_t      fo_flag;
  logic [16:0] fall_d;
  logic [16:0] fall_q;

  assign fo_flag = fd_flag_q[FDIV_STEPS-1];

  always_comb begin
    priority if (fo_flag.zero) begin
      fall_d = 17'd0;
    end else if (fo_flag.eps_zero) begin
      fall_d = fo_flag.num_ge ? ONE_Q16 : 17'd0;
    end else if (fo_flag.kill) begin
      fall_d = 17'd0;
    end else if (fo_flag.sat) begin
      fall_d = ONE_Q16;
    end else begin
      fall_d = {1'b0, fd_quo_q[FDIV_STEPS-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fall_q <= fall_d;
    end
  end

  // Output word register.
  logic [16:0] out_att_q;
  logic [16:0] out_fall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_hold) begin
      out_valid_q <= vld_q[FALL_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_hold) begin
      out_att_q  <= att_dly_q[ATT_PAD-1];
      out_fall_q <= fall_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign attenuation_o  = out_att_q;
  assign cone_falloff_o = out_fall_q;

  // Checks on pipeline control and result range.
  ap_block_on_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[FALL_LAT-1] && out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("finished word not held back while the output is stalled");

  ap_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted word did not enter the pipeline");

  ap_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved while frozen");

  ap_att_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (attenuation_o <= ONE_Q16))
    else $error("attenuation above 1.0");

  ap_fall_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cone_falloff_o <= ONE_Q16))
    else $error("cone falloff above 1.0");

endmodule
